>>> rtl/xerd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xerd_pkg
// Shared constants, name tables and types of the XML entity reference decoder.
// ----------------------------------------------------------------------------
package xerd_pkg;

  localparam int MAX_REF_LEN = 40;
  localparam int CNT_W       = $clog2(MAX_REF_LEN + 1);
  localparam int ADDR_W      = $clog2(MAX_REF_LEN);
  localparam int MAX_DIGITS  = 31;
  localparam int VAL_W       = 12;
  localparam int NUM_NAMES   = 5;

  localparam logic [VAL_W-1:0] CHAR_MAX = 12'h07F;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_XL   = 8'h78;
  localparam logic [7:0] CH_XU   = 8'h58;

  // lt, gt, amp, apos, quot; first character in the low byte
  localparam logic [NUM_NAMES-1:0][3:0][7:0] NAME_CHARS = {
    32'h746F7571, 32'h736F7061, 32'h00706D61, 32'h00007467, 32'h0000746C
  };
  localparam logic [NUM_NAMES-1:0][2:0] NAME_SIZE = {3'd4, 3'd4, 3'd3, 3'd2, 3'd2};
  localparam logic [NUM_NAMES-1:0][7:0] NAME_VAL = {8'h22, 8'h27, 8'h26, 8'h3E, 8'h3C};

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_REF,
    MODE_SKIP
  } scan_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AMP,
    ST_BODY,
    ST_TAIL
  } ctl_state_t;

  typedef struct packed {
    logic num;
    logic hex;
    logic bad;
    logic big;
  } ref_flags_t;

  typedef struct packed {
    logic accept;
    logic emit_amp;
    logic emit_body;
    logic emit_tail;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic dump;
    logic body_empty;
    logic body_last;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/xml_entity_reference_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xml_entity_reference_decoder_top
// Replaces XML entity and character references in a stream of text bytes.
//
// Input: one text byte per transfer on in_tdata, in_tlast on the final byte
// of a chunk. Output: one byte per transfer on out_tdata, out_tuser = 1 when
// a byte is carried (0 only on a bare end-of-chunk marker), out_tlast on the
// final transfer of a chunk.
// Plain text and decoded references take one input byte per cycle unless
// the output stalls; results leave through a single output register in the
// cycle after acceptance. Bytes inside an open reference produce nothing
// until ';', chunk end or a full body store. A rejected or cut-off reference
// is replayed literally ('&', stored body, final byte) with in_tready low,
// one store byte a cycle unless stalled, as sequenced by the controller.
// When the receiver stalls, the output register holds and in_tready drops.
// Reset (synchronous, rst_n low) returns to plain text with no open
// reference and an empty output register; the body store is not cleared.
// ----------------------------------------------------------------------------
module xml_entity_reference_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // [0] has_byte
  output logic            out_tlast
);

  xerd_pkg::dp_cmd_t    cmd;
  xerd_pkg::dp_status_t st;

  xerd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  xerd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .st         (st)
  );

endmodule
`default_nettype wire

>>> rtl/xerd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xerd_dp
// Datapath: scan mode, reference body store, numeric value, name matching,
// replay index and the output register.
// ----------------------------------------------------------------------------
module xerd_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [7:0]          in_tdata,
  input  wire logic                in_tlast,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [7:0]               out_tdata,
  output logic                     out_tuser,
  output logic                     out_tlast,
  input  wire xerd_pkg::dp_cmd_t   cmd,
  output xerd_pkg::dp_status_t     st
);

  xerd_pkg::scan_mode_t                mode_r, mode_nxt, mode_after;
  logic [xerd_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [7:0]                          cv_r, cv_nxt, cv_app;
  xerd_pkg::ref_flags_t                flags_r, flags_nxt, flags_app;
  logic [xerd_pkg::NUM_NAMES-1:0]      alive_r, alive_nxt, alive_app;
  logic [7:0]                          tail_byte_r, tail_byte_nxt;
  logic                                tail_last_r, tail_last_nxt;
  logic [xerd_pkg::ADDR_W-1:0]         idx_r, idx_nxt;
  logic [7:0]                          rdata_r;
  logic [7:0]                          mem [xerd_pkg::MAX_REF_LEN];
  logic                                ov_r, ov_nxt;
  logic [7:0]                          ob_r, ob_nxt;
  logic                                oh_r, oh_nxt;
  logic                                ol_r, ol_nxt;

  logic [7:0]                          b;
  logic                                last;
  logic                                is_dec, is_hex_lo, is_hex_up, dig_ok;
  logic [3:0]                          digit;
  logic [xerd_pkg::VAL_W-1:0]          prod, val;
  logic                                num_path, num_ok, name_hit, res_ok;
  logic [7:0]                          name_val, res_val;
  logic [xerd_pkg::CNT_W-1:0]          ndig;
  logic                                emit_one, dump, append, marker;
  logic [7:0]                          emit_val;
  logic                                body_last;

  assign b    = in_tdata;
  assign last = in_tlast;

  // digit decode and running value
  always_comb begin
    is_dec    = (b >= 8'h30) && (b <= 8'h39);
    is_hex_lo = flags_r.hex && (b >= 8'h61) && (b <= 8'h66);
    is_hex_up = flags_r.hex && (b >= 8'h41) && (b <= 8'h46);
    dig_ok    = is_dec || is_hex_lo || is_hex_up;
    digit     = is_dec ? b[3:0] : b[3:0] + 4'd9;
    if (flags_r.hex) begin
      prod = {cv_r, 4'b0000};
    end else begin
      prod = {1'b0, cv_r, 3'b000} + {3'b000, cv_r, 1'b0};
    end
    val = prod + xerd_pkg::VAL_W'(digit);
  end

  // body update for one appended byte
  always_comb begin
    flags_app = flags_r;
    cv_app    = cv_r;
    if (cnt_r == '0) begin
      if (b == xerd_pkg::CH_HASH) flags_app.num = 1'b1;
    end else if (flags_r.num) begin
      if (cnt_r == xerd_pkg::CNT_W'(1) && (b == xerd_pkg::CH_XL || b == xerd_pkg::CH_XU)) begin
        flags_app.hex = 1'b1;
      end else if (!dig_ok) begin
        flags_app.bad = 1'b1;
      end else if (!flags_r.big) begin
        if (val > xerd_pkg::CHAR_MAX) flags_app.big = 1'b1;
        else cv_app = val[7:0];
      end
    end
    for (int i = 0; i < xerd_pkg::NUM_NAMES; i++) begin
      alive_app[i] = alive_r[i] && (cnt_r < xerd_pkg::CNT_W'(xerd_pkg::NAME_SIZE[i])) &&
                     (b == xerd_pkg::NAME_CHARS[i][cnt_r[1:0]]);
    end
  end

  // resolve the stored body at ';'
  always_comb begin
    num_path = flags_r.num && (cnt_r >= xerd_pkg::CNT_W'(2));
    ndig     = flags_r.hex ? cnt_r - xerd_pkg::CNT_W'(2) : cnt_r - xerd_pkg::CNT_W'(1);
    num_ok   = !(flags_r.hex && cnt_r < xerd_pkg::CNT_W'(3)) &&
               (ndig <= xerd_pkg::CNT_W'(xerd_pkg::MAX_DIGITS)) &&
               !flags_r.bad && !flags_r.big;
    name_hit = 1'b0;
    name_val = 8'h00;
    for (int i = 0; i < xerd_pkg::NUM_NAMES; i++) begin
      if (alive_r[i] && cnt_r == xerd_pkg::CNT_W'(xerd_pkg::NAME_SIZE[i])) begin
        name_hit = 1'b1;
        name_val = xerd_pkg::NAME_VAL[i];
      end
    end
    res_ok  = num_path ? num_ok : name_hit;
    res_val = num_path ? cv_r : name_val;
  end

  // per-transfer decision
  always_comb begin
    emit_one   = 1'b0;
    emit_val   = b;
    dump       = 1'b0;
    append     = 1'b0;
    mode_after = mode_r;
    case (mode_r)
      xerd_pkg::MODE_REF: begin
        if (b == xerd_pkg::CH_SEMI) begin
          if (res_ok) begin
            emit_one = (res_val != 8'h00);
            emit_val = res_val;
          end else begin
            dump = 1'b1;
          end
          mode_after = xerd_pkg::MODE_PLAIN;
        end else if (last || cnt_r >= xerd_pkg::CNT_W'(xerd_pkg::MAX_REF_LEN)) begin
          dump       = 1'b1;
          mode_after = xerd_pkg::MODE_SKIP;
        end else begin
          append = 1'b1;
        end
      end
      xerd_pkg::MODE_SKIP: begin
        emit_one = 1'b1;
        if (b == xerd_pkg::CH_SEMI) mode_after = xerd_pkg::MODE_PLAIN;
      end
      default: begin
        if (b == xerd_pkg::CH_AMP && !last) begin
          mode_after = xerd_pkg::MODE_REF;
        end else begin
          emit_one = 1'b1;
        end
      end
    endcase
    if (last) mode_after = xerd_pkg::MODE_PLAIN;
    marker = last && !emit_one && !dump;
  end

  assign body_last = (xerd_pkg::CNT_W'(idx_r) + xerd_pkg::CNT_W'(1)) == cnt_r;

  always_comb begin
    st.slot_free  = !ov_r || out_tready;
    st.dump       = dump;
    st.body_empty = (cnt_r == '0);
    st.body_last  = body_last;
  end

  // next state
  always_comb begin
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    cv_nxt        = cv_r;
    flags_nxt     = flags_r;
    alive_nxt     = alive_r;
    tail_byte_nxt = tail_byte_r;
    tail_last_nxt = tail_last_r;
    idx_nxt       = idx_r;
    ov_nxt        = ov_r && !out_tready;
    ob_nxt        = ob_r;
    oh_nxt        = oh_r;
    ol_nxt        = ol_r;
    if (cmd.accept) begin
      mode_nxt      = mode_after;
      tail_byte_nxt = b;
      tail_last_nxt = last;
      idx_nxt       = '0;
      if (append) begin
        cnt_nxt   = cnt_r + xerd_pkg::CNT_W'(1);
        cv_nxt    = cv_app;
        flags_nxt = flags_app;
        alive_nxt = alive_app;
      end else if (!dump) begin
        cnt_nxt   = '0;
        cv_nxt    = 8'h00;
        flags_nxt = '0;
        alive_nxt = '1;
      end
      if (emit_one) begin
        ov_nxt = 1'b1;
        ob_nxt = emit_val;
        oh_nxt = 1'b1;
        ol_nxt = last;
      end else if (marker) begin
        ov_nxt = 1'b1;
        ob_nxt = 8'h00;
        oh_nxt = 1'b0;
        ol_nxt = 1'b1;
      end
    end
    if (cmd.emit_amp) begin
      ov_nxt = 1'b1;
      ob_nxt = xerd_pkg::CH_AMP;
      oh_nxt = 1'b1;
      ol_nxt = 1'b0;
    end
    if (cmd.emit_body) begin
      ov_nxt = 1'b1;
      ob_nxt = rdata_r;
      oh_nxt = 1'b1;
      ol_nxt = 1'b0;
      if (!body_last) idx_nxt = idx_r + xerd_pkg::ADDR_W'(1);
    end
    if (cmd.emit_tail) begin
      ov_nxt    = 1'b1;
      ob_nxt    = tail_byte_r;
      oh_nxt    = 1'b1;
      ol_nxt    = tail_last_r;
      cnt_nxt   = '0;
      cv_nxt    = 8'h00;
      flags_nxt = '0;
      alive_nxt = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= xerd_pkg::MODE_PLAIN;
      cnt_r   <= '0;
      cv_r    <= 8'h00;
      flags_r <= '0;
      alive_r <= '1;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      cv_r    <= cv_nxt;
      flags_r <= flags_nxt;
      alive_r <= alive_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_byte_r <= tail_byte_nxt;
    tail_last_r <= tail_last_nxt;
    ob_r        <= ob_nxt;
    oh_r        <= oh_nxt;
    ol_r        <= ol_nxt;
  end

  // body store, read address always one step ahead so rdata_r matches idx_r
  always_ff @(posedge clk) begin
    if (cmd.accept && append) mem[cnt_r[xerd_pkg::ADDR_W-1:0]] <= b;
    rdata_r <= mem[idx_nxt];
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tuser  = oh_r;
  assign out_tlast  = ol_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= xerd_pkg::CNT_W'(xerd_pkg::MAX_REF_LEN))
    else $error("body count past store depth");

  a_tail_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_tail |=> (cnt_r == '0) && (flags_r == '0))
    else $error("reference not cleared after replay");

endmodule
`default_nettype wire

>>> rtl/xerd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xerd_ctrl
// Controller: takes input transfers and sequences literal replay of a
// rejected or cut-off reference ('&', stored body, final byte).
// ----------------------------------------------------------------------------
module xerd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire xerd_pkg::dp_status_t st,
  output xerd_pkg::dp_cmd_t         cmd
);

  xerd_pkg::ctl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      xerd_pkg::ST_IDLE: begin
        if (in_tvalid && st.slot_free && st.dump) state_nxt = xerd_pkg::ST_AMP;
      end
      xerd_pkg::ST_AMP: begin
        if (st.slot_free) state_nxt = st.body_empty ? xerd_pkg::ST_TAIL : xerd_pkg::ST_BODY;
      end
      xerd_pkg::ST_BODY: begin
        if (st.slot_free && st.body_last) state_nxt = xerd_pkg::ST_TAIL;
      end
      xerd_pkg::ST_TAIL: begin
        if (st.slot_free) state_nxt = xerd_pkg::ST_IDLE;
      end
      default: state_nxt = xerd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      xerd_pkg::ST_IDLE: begin
        in_tready  = st.slot_free;
        cmd.accept = in_tvalid && st.slot_free;
      end
      xerd_pkg::ST_AMP:  cmd.emit_amp  = st.slot_free;
      xerd_pkg::ST_BODY: cmd.emit_body = st.slot_free;
      xerd_pkg::ST_TAIL: cmd.emit_tail = st.slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xerd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_body_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == xerd_pkg::ST_BODY) |-> !st.body_empty)
    else $error("replaying an empty body");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.emit_amp, cmd.emit_body, cmd.emit_tail}))
    else $error("more than one datapath command");

endmodule
`default_nettype wire
